/* hdl/ftcq_pkg.sv */
// Shared types, constants and the Hilbert curve function of the frame top-k quantizer.
`default_nettype none
package ftcq_pkg;

   localparam int MEL_BANDS   = 128;
   localparam int BAND_W      = $clog2(MEL_BANDS);
   localparam int IN_W        = 16;
   localparam int SUM_W       = IN_W + 1;
   localparam int CHAN_W      = BAND_W - 1;
   localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(MEL_BANDS / 2 - 1);

   localparam int AMP_LEVELS  = 81;
   localparam int LVL_W       = $clog2(AMP_LEVELS);
   localparam int NUM_W       = SUM_W + LVL_W;
   localparam int CNT_W       = $clog2(LVL_W);

   localparam int RANK_OUT_W  = 3;
   localparam int AMP_W       = 7;
   localparam int GRID_W      = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CHAN_W-1:0]       chan;
   } chan_item_type;

   typedef enum logic [1:0] {
      BK_RUN,
      BK_LOAD,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // Position of cell (x, y) along the order-3 Hilbert curve.
   function automatic logic [GRID_W-1:0] curve_pos(input logic [2:0] xi, input logic [2:0] yi);
      logic [2:0]        x;
      logic [2:0]        y;
      logic [2:0]        t;
      logic              rx;
      logic              ry;
      logic [GRID_W-1:0] d;
      x = xi;
      y = yi;
      d = '0;
      for (int s = 2; s >= 0; s--) begin
         rx = x[s];
         ry = y[s];
         d  = {d[GRID_W-3:0], rx, rx ^ ry};
         if (!ry) begin
            if (rx) begin
               x = ~x;
               y = ~y;
            end
            t = x;
            x = y;
            y = t;
         end
      end
      return d;
   endfunction

endpackage
`default_nettype wire

/* hdl/frame_topk_channel_quantizer_unit.sv */
// Top level of the frame top-k channel quantizer: front end, queue and back end.
// Bands are taken one per cycle while the queue has room; the back end retires one
// channel per cycle while it is not emitting results. After the last channel of a frame
// each result word is computed by a load state and the 7-step restoring divider, and
// the next one starts once the previous word is taken. Reset (synchronous, active high)
// empties the queue, clears the top list and starts a new frame at band 0.
`default_nettype none
module frame_topk_channel_quantizer_unit
   import ftcq_pkg::*;
#(
   parameter int TOP_COUNT = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [IN_W-1:0] req_mel_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [RANK_OUT_W-1:0]       rsp_rank,
   output logic [CHAN_W-1:0]           rsp_channel,
   output logic [AMP_W-1:0]            rsp_amp_level,
   output logic [GRID_W-1:0]           rsp_grid_pos_plain,
   output logic [GRID_W-1:0]           rsp_grid_pos_reversed,
   output logic [GRID_W-1:0]           rsp_grid_pos_mirror_y,
   output logic [GRID_W-1:0]           rsp_grid_pos_mirror_x,
   output logic                        rsp_frame_done
);

   chan_item_type push_item;
   chan_item_type pop_item;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;

   ftcq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mel_value (req_mel_value),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   ftcq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   ftcq_back #(
      .TOP_COUNT (TOP_COUNT)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_item                (pop_item),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rank              (rsp_rank),
      .rsp_channel           (rsp_channel),
      .rsp_amp_level         (rsp_amp_level),
      .rsp_grid_pos_plain    (rsp_grid_pos_plain),
      .rsp_grid_pos_reversed (rsp_grid_pos_reversed),
      .rsp_grid_pos_mirror_y (rsp_grid_pos_mirror_y),
      .rsp_grid_pos_mirror_x (rsp_grid_pos_mirror_x),
      .rsp_frame_done        (rsp_frame_done)
   );

endmodule
`default_nettype wire

/* hdl/ftcq_front.sv */
// Front end: pairs adjacent bands into channel sums and pushes them into the queue.
`default_nettype none
module ftcq_front
   import ftcq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic signed [IN_W-1:0] req_mel_value,
   input  wire logic                   q_full,
   output logic                        q_push,
   output chan_item_type               q_item
);

   logic [BAND_W-1:0] band_ff;
   logic [BAND_W-1:0] band_in;
   logic [IN_W-1:0]   pending_ff;
   logic [IN_W-1:0]   pending_in;
   logic              accept;

   // Only the second band of a pair needs room in the queue.
   assign req_stall = band_ff[0] & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = accept & band_ff[0];

   assign q_item.sum  = $signed({pending_ff[IN_W-1], pending_ff})
                      + $signed({req_mel_value[IN_W-1], req_mel_value});
   assign q_item.chan = band_ff[BAND_W-1:1];

   assign band_in    = accept ? band_ff + BAND_W'(1) : band_ff;
   assign pending_in = (accept && !band_ff[0]) ? req_mel_value : pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
      end else begin
         band_ff <= band_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
   end

endmodule
`default_nettype wire

/* hdl/ftcq_queue.sv */
// Short queue of channel sums between the front end and the back end.
`default_nettype none
module ftcq_queue
   import ftcq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire chan_item_type push_item,
   output logic               full,
   input  wire logic          pop,
   output logic               valid,
   output chan_item_type      pop_item
);

   chan_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   assign wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("word pushed into a full queue");

   a_count_tracks_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QCNT_W'(QUEUE_DEPTH)) |-> (QPTR_W'(wr_ptr_ff - rd_ptr_ff) == QPTR_W'(count_ff)))
      else $error("queue count disagrees with pointers");
`endif

endmodule
`default_nettype wire

/* hdl/ftcq_back.sv */
// Back end: min/max and top list per channel, then per-rank level division and result output.
`default_nettype none
module ftcq_back
   import ftcq_pkg::*;
#(
   parameter int TOP_COUNT = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire chan_item_type        q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [RANK_OUT_W-1:0]     rsp_rank,
   output logic [CHAN_W-1:0]         rsp_channel,
   output logic [AMP_W-1:0]          rsp_amp_level,
   output logic [GRID_W-1:0]         rsp_grid_pos_plain,
   output logic [GRID_W-1:0]         rsp_grid_pos_reversed,
   output logic [GRID_W-1:0]         rsp_grid_pos_mirror_y,
   output logic [GRID_W-1:0]         rsp_grid_pos_mirror_x,
   output logic                      rsp_frame_done
);

   localparam int RANK_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam logic [RANK_W-1:0] RANK_LAST = RANK_W'(TOP_COUNT - 1);

   back_state_type          state_ff;
   back_state_type          state_in;

   logic signed [SUM_W-1:0] low_ff;
   logic signed [SUM_W-1:0] low_in;
   logic signed [SUM_W-1:0] high_ff;
   logic signed [SUM_W-1:0] high_in;
   logic signed [SUM_W-1:0] best_sum_ff  [TOP_COUNT];
   logic signed [SUM_W-1:0] best_sum_in  [TOP_COUNT];
   logic [CHAN_W-1:0]       best_chan_ff [TOP_COUNT];
   logic [CHAN_W-1:0]       best_chan_in [TOP_COUNT];
   logic [TOP_COUNT-1:0]    filled_ff;
   logic [TOP_COUNT-1:0]    filled_in;

   logic [RANK_W-1:0]       rank_ff;
   logic [RANK_W-1:0]       rank_in;
   logic [NUM_W-1:0]        rem_ff;
   logic [NUM_W-1:0]        rem_in;
   logic [NUM_W-1:0]        dsh_ff;
   logic [NUM_W-1:0]        dsh_in;
   logic [LVL_W-1:0]        quo_ff;
   logic [LVL_W-1:0]        quo_in;
   logic [CNT_W-1:0]        cnt_ff;
   logic [CNT_W-1:0]        cnt_in;

   logic [RANK_OUT_W-1:0]   out_rank_ff;
   logic [RANK_OUT_W-1:0]   out_rank_in;
   logic [CHAN_W-1:0]       out_chan_ff;
   logic [CHAN_W-1:0]       out_chan_in;
   logic [AMP_W-1:0]        out_amp_ff;
   logic [AMP_W-1:0]        out_amp_in;
   logic [GRID_W-1:0]       out_plain_ff;
   logic [GRID_W-1:0]       out_plain_in;
   logic [GRID_W-1:0]       out_mir_y_ff;
   logic [GRID_W-1:0]       out_mir_y_in;
   logic [GRID_W-1:0]       out_mir_x_ff;
   logic [GRID_W-1:0]       out_mir_x_in;
   logic                    out_done_ff;
   logic                    out_done_in;

   logic [TOP_COUNT-1:0]    gt;
   logic [TOP_COUNT-1:0]    sh_gt;
   logic signed [SUM_W-1:0] sh_sum  [TOP_COUNT];
   logic [CHAN_W-1:0]       sh_chan [TOP_COUNT];
   logic [TOP_COUNT-1:0]    sh_filled;
   logic [SUM_W-1:0]        range_w;
   logic [SUM_W-1:0]        diff_w;
   logic [NUM_W-1:0]        rem_sub;
   logic                    qbit;
   logic [LVL_W-1:0]        quo_next;
   logic [CHAN_W-1:0]       sel_chan;

   assign range_w  = SUM_W'(high_ff - low_ff);
   assign diff_w   = SUM_W'(best_sum_ff[rank_ff] - low_ff);
   assign rem_sub  = rem_ff - dsh_ff;
   assign qbit     = (rem_ff >= dsh_ff);
   assign quo_next = {quo_ff[LVL_W-2:0], qbit};
   assign sel_chan = best_chan_ff[rank_ff];

   // A later entry ranks below the new sum when it is empty or strictly smaller,
   // so equal sums keep the earlier channel in front.
   always_comb begin
      for (int k = 0; k < TOP_COUNT; k++) begin
         gt[k] = !filled_ff[k] || ($signed(q_item.sum) > best_sum_ff[k]);
      end
      sh_gt[0]     = 1'b0;
      sh_sum[0]    = best_sum_ff[0];
      sh_chan[0]   = best_chan_ff[0];
      sh_filled[0] = 1'b0;
      for (int j = 1; j < TOP_COUNT; j++) begin
         sh_gt[j]     = gt[j-1];
         sh_sum[j]    = best_sum_ff[j-1];
         sh_chan[j]   = best_chan_ff[j-1];
         sh_filled[j] = filled_ff[j-1];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (q_valid && (q_item.chan == CHAN_LAST)) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (cnt_ff == '0) begin
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_stall) begin
               state_in = (rank_ff == RANK_LAST) ? BK_RUN : BK_LOAD;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      low_in       = low_ff;
      high_in      = high_ff;
      best_sum_in  = best_sum_ff;
      best_chan_in = best_chan_ff;
      filled_in    = filled_ff;
      rank_in      = rank_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_rank_in  = out_rank_ff;
      out_chan_in  = out_chan_ff;
      out_amp_in   = out_amp_ff;
      out_plain_in = out_plain_ff;
      out_mir_y_in = out_mir_y_ff;
      out_mir_x_in = out_mir_x_ff;
      out_done_in  = out_done_ff;
      q_pop        = 1'b0;
      case (state_ff)
         BK_RUN: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.chan == '0) begin
                  low_in  = q_item.sum;
                  high_in = q_item.sum;
               end else begin
                  if ($signed(q_item.sum) < low_ff) begin
                     low_in = q_item.sum;
                  end
                  if ($signed(q_item.sum) > high_ff) begin
                     high_in = q_item.sum;
                  end
               end
               for (int j = 0; j < TOP_COUNT; j++) begin
                  if (sh_gt[j]) begin
                     best_sum_in[j]  = sh_sum[j];
                     best_chan_in[j] = sh_chan[j];
                     filled_in[j]    = sh_filled[j];
                  end else if (gt[j]) begin
                     best_sum_in[j]  = q_item.sum;
                     best_chan_in[j] = q_item.chan;
                     filled_in[j]    = 1'b1;
                  end
               end
               rank_in = '0;
            end
         end
         BK_LOAD: begin
            rem_in = NUM_W'(diff_w) * NUM_W'(AMP_LEVELS - 1);
            dsh_in = NUM_W'(range_w) << (LVL_W - 1);
            quo_in = '0;
            cnt_in = CNT_W'(LVL_W - 1);
         end
         BK_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (qbit) begin
               rem_in = rem_sub;
            end
            dsh_in = dsh_ff >> 1;
            quo_in = quo_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               out_rank_in  = RANK_OUT_W'(rank_ff);
               out_chan_in  = sel_chan;
               out_amp_in   = (range_w == '0) ? '0 : AMP_W'(quo_next);
               out_plain_in = curve_pos(sel_chan[2:0], sel_chan[5:3]);
               out_mir_y_in = curve_pos(sel_chan[2:0], ~sel_chan[5:3]);
               out_mir_x_in = curve_pos(~sel_chan[2:0], sel_chan[5:3]);
               out_done_in  = (rank_ff == RANK_LAST);
            end
         end
         BK_OUT: begin
            if (!rsp_stall) begin
               if (rank_ff == RANK_LAST) begin
                  filled_in = '0;
               end else begin
                  rank_in = rank_ff + RANK_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_RUN;
         filled_ff <= '0;
         rank_ff   <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         rank_ff   <= rank_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      best_sum_ff  <= best_sum_in;
      best_chan_ff <= best_chan_in;
      rem_ff       <= rem_in;
      dsh_ff       <= dsh_in;
      quo_ff       <= quo_in;
      out_rank_ff  <= out_rank_in;
      out_chan_ff  <= out_chan_in;
      out_amp_ff   <= out_amp_in;
      out_plain_ff <= out_plain_in;
      out_mir_y_ff <= out_mir_y_in;
      out_mir_x_ff <= out_mir_x_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid             = (state_ff == BK_OUT);
   assign rsp_rank              = out_rank_ff;
   assign rsp_channel           = out_chan_ff;
   assign rsp_amp_level         = out_amp_ff;
   assign rsp_grid_pos_plain    = out_plain_ff;
   assign rsp_grid_pos_reversed = ~out_plain_ff;
   assign rsp_grid_pos_mirror_y = out_mir_y_ff;
   assign rsp_grid_pos_mirror_x = out_mir_x_ff;
   assign rsp_frame_done        = out_done_ff;

`ifndef NO_ASSERTIONS
   a_filled_is_prefix: assert property (@(posedge clock) disable iff (reset)
      (filled_ff & (filled_ff + TOP_COUNT'(1))) == '0)
      else $error("top list has a gap");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_amp_level <= AMP_W'(AMP_LEVELS - 1)))
      else $error("amplitude level above ceiling");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_done) |=> (filled_ff == '0) && (state_ff == BK_RUN))
      else $error("top list not cleared after last word");

   a_no_pop_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_RUN) |-> !q_pop)
      else $error("queue popped during result phase");
`endif

endmodule
`default_nettype wire

/* bench/tb_frame_topk_channel_quantizer_unit.sv */
// Self-checking testbench for the frame top-k channel quantizer, with random idling on both sides.
`timescale 1ns / 1ps
module tb_frame_topk_channel_quantizer_unit;
   import ftcq_pkg::*;

   localparam int TOP_N       = 8;
   localparam int FRAME_COUNT = 1;
   localparam int DRAIN_WAIT  = 150;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      int rank;
      int channel;
      int amp_level;
      int pos_plain;
      int pos_reversed;
      int pos_mirror_y;
      int pos_mirror_x;
      int frame_done;
   } topk_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [IN_W-1:0] req_mel_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RANK_OUT_W-1:0] rsp_rank;
   logic [CHAN_W-1:0] rsp_channel;
   logic [AMP_W-1:0] rsp_amp_level;
   logic [GRID_W-1:0] rsp_grid_pos_plain;
   logic [GRID_W-1:0] rsp_grid_pos_reversed;
   logic [GRID_W-1:0] rsp_grid_pos_mirror_y;
   logic [GRID_W-1:0] rsp_grid_pos_mirror_x;
   logic rsp_frame_done;

   logic signed [IN_W-1:0] band_queue[$];
   topk_word_type expected_words[$];
   int error_count = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit calm_in = 1'b0;
   bit calm_out = 1'b0;

   // Predictor state: one frame in flight.
   logic signed [IN_W-1:0] held_band = '0;
   int band_pos = 0;
   int low_sum = 0;
   int high_sum = 0;
   int top_sum[TOP_N];
   int top_chan[TOP_N];
   bit top_used[TOP_N];

   frame_topk_channel_quantizer_unit #(.TOP_COUNT(TOP_N)) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mel_value         (req_mel_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_rank              (rsp_rank),
      .rsp_channel           (rsp_channel),
      .rsp_amp_level         (rsp_amp_level),
      .rsp_grid_pos_plain    (rsp_grid_pos_plain),
      .rsp_grid_pos_reversed (rsp_grid_pos_reversed),
      .rsp_grid_pos_mirror_y (rsp_grid_pos_mirror_y),
      .rsp_grid_pos_mirror_x (rsp_grid_pos_mirror_x),
      .rsp_frame_done        (rsp_frame_done)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Walk the order-3 Hilbert curve from the coarsest quadrant down.
   function automatic int hilbert_index(int px, int py);
      int x, y, d, rx, ry, t;
      x = px & 7;
      y = py & 7;
      d = 0;
      for (int s = 4; s > 0; s = s >> 1) begin
         rx = ((x & s) != 0) ? 1 : 0;
         ry = ((y & s) != 0) ? 1 : 0;
         d = (d << 2) | ((3 * rx) ^ ry);
         if (ry == 0) begin
            if (rx == 1) begin
               x = 7 - x;
               y = 7 - y;
            end
            t = x;
            x = y;
            y = t;
         end
      end
      return d & 63;
   endfunction

   function automatic int draw_wait(bit calm);
      return calm ? 0 : int'($urandom_range(0, 18));
   endfunction

   // Fold one accepted band into the predicted frame; emit the top list at frame end.
   task automatic predict_band(input logic signed [IN_W-1:0] value);
      int idx, sum, ch, last_k, range_v, x, y;
      longint lvl;
      bit placed;
      topk_word_type w;
      idx = band_pos;
      band_pos = (band_pos + 1) % MEL_BANDS;
      if ((idx & 1) == 0) begin
         held_band = value;
         return;
      end
      sum = int'(held_band) + int'(value);
      ch = idx >> 1;
      if (ch == 0) begin
         low_sum = sum;
         high_sum = sum;
      end else begin
         if (sum < low_sum) low_sum = sum;
         if (sum > high_sum) high_sum = sum;
      end
      // Strictly greater wins, so an earlier channel keeps its place on a tie.
      placed = 1'b0;
      for (int k = 0; k < TOP_N; k++) begin
         if (!placed && (!top_used[k] || sum > top_sum[k])) begin
            for (int j = TOP_N - 1; j > k; j--) begin
               top_sum[j] = top_sum[j-1];
               top_chan[j] = top_chan[j-1];
               top_used[j] = top_used[j-1];
            end
            top_sum[k] = sum;
            top_chan[k] = ch;
            top_used[k] = 1'b1;
            placed = 1'b1;
         end
      end
      if (idx != MEL_BANDS - 1) return;
      last_k = -1;
      for (int k = 0; k < TOP_N; k++)
         if (top_used[k]) last_k = k;
      range_v = high_sum - low_sum;
      for (int k = 0; k < TOP_N; k++) begin
         if (top_used[k]) begin
            lvl = 0;
            if (range_v != 0) begin
               lvl = (longint'(top_sum[k] - low_sum) * (AMP_LEVELS - 1)) / range_v;
               if (lvl > AMP_LEVELS - 1) lvl = AMP_LEVELS - 1;
            end
            x = top_chan[k] & 7;
            y = top_chan[k] >> 3;
            w.rank = k;
            w.channel = top_chan[k];
            w.amp_level = int'(lvl);
            w.pos_plain = hilbert_index(x, y);
            w.pos_reversed = 63 - w.pos_plain;
            w.pos_mirror_y = hilbert_index(x, 7 - y);
            w.pos_mirror_x = hilbert_index(7 - x, y);
            w.frame_done = (k == last_k) ? 1 : 0;
            expected_words.push_back(w);
         end
      end
      for (int k = 0; k < TOP_N; k++) top_used[k] = 1'b0;
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Random frame flavors: full range, narrow (many ties), flat with a spike, rail values.
   task automatic build_frame(input int kind);
      int spike;
      int v;
      spike = $urandom_range(0, MEL_BANDS);
      for (int b = 0; b < MEL_BANDS; b++) begin
         case (kind)
            0: begin
               v = $urandom_range(0, 65535);
            end
            1: begin
               v = int'($urandom_range(0, 6)) - 3;
            end
            2: begin
               v = (b == spike) ? int'($urandom_range(0, 65535)) : 1234;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: v = -32768;
                  1: v = 32767;
                  2: v = 0;
                  3: v = -1;
                  default: v = $urandom_range(0, 65535);
               endcase
            end
         endcase
         band_queue.push_back(IN_W'(v));
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Driver: present the next band after the drawn number of idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_band(req_mel_value);
            if ($urandom_range(0, 99) == 0) calm_in = !calm_in;
            gap_left = draw_wait(calm_in);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (band_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_mel_value <= band_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each taken result word and hold stall for the drawn cycles.
   always @(posedge clock) begin
      topk_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word, got rank %0d channel %0d", $time,
                        rsp_rank, rsp_channel);
            end else begin
               w = expected_words.pop_front();
               check_field("rank", w.rank, int'(rsp_rank));
               check_field("channel", w.channel, int'(rsp_channel));
               check_field("amp_level", w.amp_level, int'(rsp_amp_level));
               check_field("grid_pos_plain", w.pos_plain, int'(rsp_grid_pos_plain));
               check_field("grid_pos_reversed", w.pos_reversed, int'(rsp_grid_pos_reversed));
               check_field("grid_pos_mirror_y", w.pos_mirror_y, int'(rsp_grid_pos_mirror_y));
               check_field("grid_pos_mirror_x", w.pos_mirror_x, int'(rsp_grid_pos_mirror_x));
               check_field("frame_done", w.frame_done, int'(rsp_frame_done));
            end
            if ($urandom_range(0, 19) == 0) calm_out = !calm_out;
            stall_left = draw_wait(calm_out);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      // Flat frame at the negative rail: zero range and a full tie across channels.
      for (int b = 0; b < MEL_BANDS; b++) band_queue.push_back(IN_W'(-32768));
      // Three channels tie at the positive rail, channel 0 sits at the floor.
      for (int c = 0; c < MEL_BANDS / 2; c++) begin
         if (c == 3 || c == 17 || c == 63) begin
            band_queue.push_back(IN_W'(32767));
            band_queue.push_back(IN_W'(32767));
         end else if (c == 0) begin
            band_queue.push_back(IN_W'(-32768));
            band_queue.push_back(IN_W'(-32768));
         end else if (c == 40) begin
            band_queue.push_back(IN_W'(32767));
            band_queue.push_back(IN_W'(-32768));
         end else begin
            band_queue.push_back(IN_W'(c * 100));
            band_queue.push_back(IN_W'(c - c * 100));
         end
      end
      for (int f = 0; f < FRAME_COUNT; f++)
         build_frame(int'($urandom_range(0, 3)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (band_queue.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
